>>> rtl/core/scf_pkg.sv
// ----------------------------------------------------------------------------
// Stereo crossfeed filter package
// Shared widths, register codes, control word layout and the microcode ROM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scf_pkg;

  // Default sample and coefficient formats
  localparam int unsigned SAMPLE_BITS_DEF    = 24;
  localparam int unsigned COEF_FRAC_BITS_DEF = 16;

  // Fixed register and datapath widths
  localparam int unsigned B0_W    = 16;
  localparam int unsigned A1_W    = 18;
  localparam int unsigned GAIN_W  = 15;
  localparam int unsigned CFG_W   = 18;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FILT_W  = 32;
  localparam int unsigned OPA_W   = 19;
  localparam int unsigned OPB_W   = FILT_W + 1;
  localparam int unsigned PROD_W  = OPA_W + OPB_W;
  localparam int unsigned STEP_W  = 4;

  // Register reset values
  localparam logic [B0_W-1:0]          B0_RESET   = 16'd3115;
  localparam logic signed [A1_W-1:0]   A1_RESET   = -18'sd59305;
  localparam logic [GAIN_W-1:0]        GAIN_RESET = 15'd0;

  typedef logic [STEP_W-1:0] step_t;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B0   = 2'd0,
    CFG_A1   = 2'd1,
    CFG_GAIN = 2'd2
  } cfg_reg_e;

  // Multiplier coefficient operand
  typedef enum logic [1:0] {
    OPA_B0   = 2'd0,
    OPA_A1   = 2'd1,
    OPA_GAIN = 2'd2
  } opa_sel_e;

  // Multiplier data operand
  typedef enum logic [2:0] {
    OPB_SUM_L = 3'd0,
    OPB_Y1_L  = 3'd1,
    OPB_SUM_R = 3'd2,
    OPB_Y1_R  = 3'd3,
    OPB_DIFF  = 3'd4
  } opb_sel_e;

  // Accumulator operation on the registered product
  typedef enum logic [1:0] {
    ACC_HOLD    = 2'd0,
    ACC_LOAD_FF = 2'd1,
    ACC_SUB     = 2'd2,
    ACC_LOAD_D  = 2'd3
  } acc_op_e;

  // Filter state write-back
  typedef enum logic [1:0] {
    WB_NONE  = 2'd0,
    WB_LEFT  = 2'd1,
    WB_RIGHT = 2'd2
  } wb_e;

  // Result register load
  typedef enum logic [1:0] {
    EMIT_NONE = 2'd0,
    EMIT_MIX  = 2'd1,
    EMIT_PASS = 2'd2
  } emit_e;

  // Sequencing after a step
  typedef enum logic [1:0] {
    JMP_NEXT   = 2'd0,
    JMP_BYPASS = 2'd1,
    JMP_END    = 2'd2
  } jmp_e;

  typedef struct packed {
    opa_sel_e opa;
    opb_sel_e opb;
    acc_op_e  acc;
    wb_e      wb;
    emit_e    emit;
    jmp_e     jmp;
    step_t    target;
  } ucode_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic   load;
    ucode_t uc;
  } scf_ctrl_t;

  localparam step_t STEP_PASS = 4'd9;

  // Microcode ROM. A product issued in one step is accumulated in the next.
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    w = '{opa: OPA_B0, opb: OPB_SUM_L, acc: ACC_HOLD, wb: WB_NONE,
          emit: EMIT_NONE, jmp: JMP_NEXT, target: '0};
    unique case (s)
      4'd0: begin
        w.opa = OPA_B0;   w.opb = OPB_SUM_L;
        w.jmp = JMP_BYPASS; w.target = STEP_PASS;
      end
      4'd1: begin
        w.opa = OPA_A1;   w.opb = OPB_Y1_L;  w.acc = ACC_LOAD_FF;
      end
      4'd2: begin
        w.opa = OPA_B0;   w.opb = OPB_SUM_R; w.acc = ACC_SUB;
      end
      4'd3: begin
        w.opa = OPA_A1;   w.opb = OPB_Y1_R;  w.acc = ACC_LOAD_FF;
        w.wb  = WB_LEFT;
      end
      4'd4: begin
        w.acc = ACC_SUB;
      end
      4'd5: begin
        w.wb  = WB_RIGHT;
      end
      4'd6: begin
        w.opa = OPA_GAIN; w.opb = OPB_DIFF;
      end
      4'd7: begin
        w.acc = ACC_LOAD_D;
      end
      4'd8: begin
        w.emit = EMIT_MIX; w.jmp = JMP_END;
      end
      4'd9: begin
        w.emit = EMIT_PASS; w.jmp = JMP_END;
      end
      default: begin
        w.jmp = JMP_END;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/scf_sequencer.sv
// ----------------------------------------------------------------------------
// Crossfeed microcode sequencer
// Step counter over the microcode ROM, request handshakes and stall control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scf_sequencer
  import scf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  logic      gain_zero_i,
  output scf_ctrl_t ctrl_o
);

  logic   busy_q, busy_d;
  step_t  step_q, step_d;
  logic   out_valid_q, out_valid_d;
  ucode_t uc;
  logic   load, stall, run;

  // Fetch the control word of the current step
  always_comb begin
    uc         = ucode_rom(step_q);
    load       = in_valid_i && !busy_q;
    stall      = busy_q && (uc.emit != EMIT_NONE) && out_valid_q && !out_ready_i;
    run        = busy_q && !stall;
    in_ready_o = !busy_q;
  end

  // Drop datapath actions while idle or stalled
  always_comb begin
    ctrl_o.load = load;
    ctrl_o.uc   = uc;
    if (!run) begin
      ctrl_o.uc.acc  = ACC_HOLD;
      ctrl_o.uc.wb   = WB_NONE;
      ctrl_o.uc.emit = EMIT_NONE;
    end
  end

  // Advance the step counter, take jumps
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (load) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (run) begin
      unique case (uc.jmp)
        JMP_NEXT:   step_d = step_q + step_t'(1);
        JMP_BYPASS: step_d = gain_zero_i ? uc.target : step_q + step_t'(1);
        JMP_END: begin
          busy_d = 1'b0;
          step_d = '0;
        end
        default: begin
          busy_d = 1'b0;
          step_d = '0;
        end
      endcase
    end
  end

  // Hold the result valid until the request is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (run && (uc.emit != EMIT_NONE)) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/scf_datapath.sv
// ----------------------------------------------------------------------------
// Crossfeed datapath
// Shared multiplier, accumulator, low-pass state and saturating result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scf_datapath
  import scf_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  scf_ctrl_t                     ctrl_i,
  input  logic [B0_W-1:0]               b0_i,
  input  logic signed [A1_W-1:0]        a1_i,
  input  logic [GAIN_W-1:0]             gain_i,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  input  logic                          end_of_block_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  output logic                          clipped_o,
  output logic                          end_of_block_out_o
);

  localparam int unsigned EXTRA_BITS = FILT_W - SAMPLE_BITS;
  localparam int unsigned ACC_W      = PROD_W + EXTRA_BITS;
  localparam int unsigned D_SHIFT    = COEF_FRAC_BITS + EXTRA_BITS;
  localparam logic signed [ACC_W-1:0] RND_F = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] RND_D = ACC_W'(1) << (D_SHIFT - 1);

  // Frame and filter state
  logic signed [SAMPLE_BITS-1:0] left_q, right_q;
  logic                          eob_q;
  logic signed [SAMPLE_BITS:0]   sum_l_q, sum_r_q;
  logic signed [SAMPLE_BITS-1:0] x1_l_q, x1_r_q;
  logic signed [FILT_W-1:0]      y1_l_q, y1_r_q;
  logic signed [OPB_W-1:0]       diff_q;

  // Arithmetic
  logic signed [OPA_W-1:0]  opa;
  logic signed [OPB_W-1:0]  opb;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_d, acc_q;
  logic signed [ACC_W-1:0]  y_shift;
  logic                     y_sat;
  logic signed [FILT_W-1:0] y_new;
  logic signed [ACC_W-1:0]  d_val, lo_full, ro_full;
  logic                     lo_sat, ro_sat;
  logic signed [SAMPLE_BITS-1:0] lo_clamped, ro_clamped;

  // Select multiplier operands
  always_comb begin
    unique case (ctrl_i.uc.opa)
      OPA_B0:   opa = OPA_W'({1'b0, b0_i});
      OPA_A1:   opa = OPA_W'(a1_i);
      OPA_GAIN: opa = OPA_W'({1'b0, gain_i});
      default:  opa = '0;
    endcase
    unique case (ctrl_i.uc.opb)
      OPB_SUM_L: opb = OPB_W'(sum_l_q);
      OPB_Y1_L:  opb = OPB_W'(y1_l_q);
      OPB_SUM_R: opb = OPB_W'(sum_r_q);
      OPB_Y1_R:  opb = OPB_W'(y1_r_q);
      OPB_DIFF:  opb = diff_q;
      default:   opb = '0;
    endcase
    prod_d = PROD_W'(opa) * PROD_W'(opb);
  end

  // Accumulate the registered product
  always_comb begin
    prod_ext = ACC_W'(prod_q);
    unique case (ctrl_i.uc.acc)
      ACC_HOLD:    acc_d = acc_q;
      ACC_LOAD_FF: acc_d = (prod_ext <<< EXTRA_BITS) + RND_F;
      ACC_SUB:     acc_d = acc_q - prod_ext;
      ACC_LOAD_D:  acc_d = prod_ext + RND_D;
      default:     acc_d = acc_q;
    endcase
  end

  // Scale the accumulator to a filtered value, saturate to 32 bits
  always_comb begin
    y_shift = acc_q >>> COEF_FRAC_BITS;
    y_sat   = !((&y_shift[ACC_W-1:FILT_W-1]) || !(|y_shift[ACC_W-1:FILT_W-1]));
    y_new   = y_sat ? {y_shift[ACC_W-1], {(FILT_W-1){~y_shift[ACC_W-1]}}}
                    : y_shift[FILT_W-1:0];
  end

  // Mix the scaled difference into both channels and saturate
  always_comb begin
    d_val   = acc_q >>> D_SHIFT;
    lo_full = ACC_W'(left_q) - d_val;
    ro_full = ACC_W'(right_q) + d_val;
    lo_sat  = !((&lo_full[ACC_W-1:SAMPLE_BITS-1]) || !(|lo_full[ACC_W-1:SAMPLE_BITS-1]));
    ro_sat  = !((&ro_full[ACC_W-1:SAMPLE_BITS-1]) || !(|ro_full[ACC_W-1:SAMPLE_BITS-1]));
    lo_clamped = lo_sat ? {lo_full[ACC_W-1], {(SAMPLE_BITS-1){~lo_full[ACC_W-1]}}}
                        : lo_full[SAMPLE_BITS-1:0];
    ro_clamped = ro_sat ? {ro_full[ACC_W-1], {(SAMPLE_BITS-1){~ro_full[ACC_W-1]}}}
                        : ro_full[SAMPLE_BITS-1:0];
  end

  // Capture the frame and the feedforward sums on request
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (ctrl_i.load) begin
      left_q  <= left_in_i;
      right_q <= right_in_i;
      eob_q   <= end_of_block_i;
      sum_l_q <= (SAMPLE_BITS+1)'(left_in_i) + (SAMPLE_BITS+1)'(x1_l_q);
      sum_r_q <= (SAMPLE_BITS+1)'(right_in_i) + (SAMPLE_BITS+1)'(x1_r_q);
    end
    if (ctrl_i.uc.wb == WB_RIGHT) begin
      diff_q <= OPB_W'(y1_l_q) - OPB_W'(y_new);
    end
  end

  // Write back filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_l_q <= '0;
      x1_r_q <= '0;
      y1_l_q <= '0;
      y1_r_q <= '0;
    end else begin
      unique case (ctrl_i.uc.wb)
        WB_LEFT: begin
          x1_l_q <= left_q;
          y1_l_q <= y_new;
        end
        WB_RIGHT: begin
          x1_r_q <= right_q;
          y1_r_q <= y_new;
        end
        default: begin
        end
      endcase
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.uc.emit)
      EMIT_MIX: begin
        left_out_o         <= lo_clamped;
        right_out_o        <= ro_clamped;
        clipped_o          <= lo_sat || ro_sat;
        end_of_block_out_o <= eob_q;
      end
      EMIT_PASS: begin
        left_out_o         <= left_q;
        right_out_o        <= right_q;
        clipped_o          <= 1'b0;
        end_of_block_out_o <= eob_q;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/stereo_crossfeed_filter.sv
// ----------------------------------------------------------------------------
// Stereo crossfeed filter
// First-order crossfeed: low-pass both channels, mix the scaled difference.
// ----------------------------------------------------------------------------
// Each request carries one stereo frame. Both channels pass through a
// first-order low-pass; the difference of the two filtered values, scaled by
// cross_gain, is taken from left and added to right, with SAMPLE_BITS-wide
// saturation flagged on clipped_o. With cross_gain at zero the frame passes unchanged and
// the filter state holds. All work runs on one shared multiplier, followed by
// a product register, stepped by a microcode ROM that takes a shorter path
// when cross_gain is zero; the final step stalls while the previous result
// still waits on out_ready_i.
// The next frame is accepted while the previous result still waits.
// Configuration writes are taken at once on cfg_we_i; write only when idle.
`timescale 1ns / 1ps

module stereo_crossfeed_filter
  import scf_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_wdata_i,
  // Input frames
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  input  logic                          end_of_block_i,
  // Output frames
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  output logic                          clipped_o,
  output logic                          end_of_block_out_o
);

  logic [B0_W-1:0]        b0_q;
  logic signed [A1_W-1:0] a1_q;
  logic [GAIN_W-1:0]      gain_q;
  logic                   gain_zero;
  scf_ctrl_t              ctrl;

  // Write configuration registers, ignore unused indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q   <= B0_RESET;
      a1_q   <= A1_RESET;
      gain_q <= GAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_B0:   b0_q   <= cfg_wdata_i[B0_W-1:0];
        CFG_A1:   a1_q   <= cfg_wdata_i[A1_W-1:0];
        CFG_GAIN: gain_q <= cfg_wdata_i[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign gain_zero = (gain_q == '0);

  scf_sequencer u_sequencer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .gain_zero_i (gain_zero),
    .ctrl_o      (ctrl)
  );

  scf_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctrl_i             (ctrl),
    .b0_i               (b0_q),
    .a1_i               (a1_q),
    .gain_i             (gain_q),
    .left_in_i          (left_in_i),
    .right_in_i         (right_in_i),
    .end_of_block_i     (end_of_block_i),
    .left_out_o         (left_out_o),
    .right_out_o        (right_out_o),
    .clipped_o          (clipped_o),
    .end_of_block_out_o (end_of_block_out_o)
  );

endmodule
